>>> rtl/pdf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the packet deframer.
package pdf_pkg;

    localparam int unsigned CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOP_BYTE   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 4'd1;

    localparam logic [7:0]  SOP_RESET  = 8'hA1;
    localparam logic [7:0]  MAXL_RESET = 8'd200;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_CRCLO   = 3'd3,
        PH_CRCHI   = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] sop_byte;
        logic [7:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic       frame_end;
        logic       crc_good;
    } result_t;

    function automatic logic [15:0] crc_update(input logic [7:0] din, input logic [15:0] crc);
        logic [7:0]  b;
        logic [15:0] r;
        b = din ^ crc[7:0];
        b = b ^ {b[3:0], 4'h0};
        r = {b, crc[15:8]} ^ {12'h000, b[7:4]} ^ {5'h00, b, 3'b000};
        return r;
    endfunction

endpackage

>>> rtl/pdf_parser.sv
// Frame parse state machine with running CRC-16 and result generation.
module pdf_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        din,
    input  pdf_pkg::cfg_t     cfg,
    output logic              res_valid,
    output pdf_pkg::result_t  res
);

    pdf_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      held_type_reg, held_type_next;
    logic [7:0]      held_length_reg, held_length_next;
    logic [15:0]     rcrc_reg, rcrc_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      count_reg, count_next;
    logic [15:0]     crc_upd;
    logic [15:0]     rcrc_full;
    logic            last;

    assign crc_upd   = pdf_pkg::crc_update(din, crc_reg);
    assign rcrc_full = {din, rcrc_reg[7:0]};
    assign last      = ({1'b0, count_reg} + 9'd1) >= {1'b0, held_length_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        rcrc_next        = rcrc_reg;
        crc_next         = crc_reg;
        count_next       = count_reg;
        unique case (phase_reg)
            pdf_pkg::PH_TYPE:
            begin
                held_type_next = din;
                crc_next       = pdf_pkg::crc_update(din, pdf_pkg::CRC_INIT);
                phase_next     = pdf_pkg::PH_LEN;
            end
            pdf_pkg::PH_LEN:
            begin
                if (din <= cfg.max_length)
                begin
                    held_length_next = din;
                    crc_next         = crc_upd;
                    phase_next       = pdf_pkg::PH_CRCLO;
                end
                else
                begin
                    phase_next = pdf_pkg::PH_IDLE;
                    crc_next   = pdf_pkg::CRC_INIT;
                end
            end
            pdf_pkg::PH_CRCLO:
            begin
                rcrc_next  = {8'h00, din};
                phase_next = pdf_pkg::PH_CRCHI;
            end
            pdf_pkg::PH_CRCHI:
            begin
                rcrc_next  = rcrc_full;
                count_next = 8'd0;
                if (held_length_reg == 8'd0)
                begin
                    phase_next = pdf_pkg::PH_IDLE;
                    crc_next   = pdf_pkg::CRC_INIT;
                end
                else
                begin
                    phase_next = pdf_pkg::PH_PAYLOAD;
                end
            end
            pdf_pkg::PH_PAYLOAD:
            begin
                if (last)
                begin
                    phase_next = pdf_pkg::PH_IDLE;
                    count_next = 8'd0;
                    crc_next   = pdf_pkg::CRC_INIT;
                end
                else
                begin
                    count_next = count_reg + 8'd1;
                    crc_next   = crc_upd;
                end
            end
            default:
            begin
                if (din == cfg.sop_byte)
                begin
                    phase_next = pdf_pkg::PH_TYPE;
                    crc_next   = pdf_pkg::CRC_INIT;
                    count_next = 8'd0;
                end
                else
                begin
                    phase_next = pdf_pkg::PH_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        res_valid        = 1'b0;
        res.has_byte     = 1'b0;
        res.data_byte    = 8'd0;
        res.byte_index   = 8'd0;
        res.frame_type   = held_type_reg;
        res.frame_length = held_length_reg;
        res.frame_end    = 1'b0;
        res.crc_good     = 1'b0;
        unique case (phase_reg)
            pdf_pkg::PH_CRCHI:
            begin
                if (held_length_reg == 8'd0)
                begin
                    res_valid     = 1'b1;
                    res.frame_end = 1'b1;
                    res.crc_good  = (crc_reg == rcrc_full);
                end
            end
            pdf_pkg::PH_PAYLOAD:
            begin
                res_valid      = 1'b1;
                res.has_byte   = 1'b1;
                res.data_byte  = din;
                res.byte_index = count_reg;
                res.frame_end  = last;
                res.crc_good   = last && (crc_upd == rcrc_reg);
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= pdf_pkg::PH_IDLE;
            held_type_reg   <= 8'd0;
            held_length_reg <= 8'd0;
            rcrc_reg        <= 16'd0;
            crc_reg         <= pdf_pkg::CRC_INIT;
            count_reg       <= 8'd0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            rcrc_reg        <= rcrc_next;
            crc_reg         <= crc_next;
            count_reg       <= count_next;
        end
    end

endmodule

>>> rtl/pdf_out_reg.sv
// Output result register with valid/stall handshake.
module pdf_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pdf_pkg::result_t  din,
    input  logic              out_stall,
    output logic              room,
    output logic              out_valid,
    output pdf_pkg::result_t  dout
);

    logic             valid_reg, valid_next;
    pdf_pkg::result_t data_reg;

    assign room       = !valid_reg || !out_stall;
    assign valid_next = room ? load : valid_reg;
    assign out_valid  = valid_reg;
    assign dout       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && load)
        begin
            data_reg <= din;
        end
    end

endmodule

>>> rtl/packet_deframer_crc16_check.sv
// Top level of the packet deframer with CRC-16 check.
//
//  channel  direction  handshake               word
//  in       sink       in_valid / in_stall     rx_byte
//  out      source     out_valid / out_stall   has_byte .. crc_good
//  cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle sustained while the output is not stalled; a taken byte passes through
// the input register and then the output register before its result is valid at the output.
// The input register feeds the parse logic, which writes the output register.
// Reset clears the parse state and loads the register defaults; no sweep follows.
// An output stall holds the result and backs up through the input register.
// cfg_ready is always high.
module packet_deframer_crc16_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            has_byte,
    output logic [7:0]                      data_byte,
    output logic [7:0]                      byte_index,
    output logic [7:0]                      frame_type,
    output logic [7:0]                      frame_length,
    output logic                            frame_end,
    output logic                            crc_good,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);

    pdf_pkg::cfg_t    cfg_reg;
    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             room;
    logic             advance;
    logic             accept;
    logic             res_valid;
    pdf_pkg::result_t res;
    pdf_pkg::result_t res_out;

    assign cfg_ready     = 1'b1;
    assign advance       = s1_valid_reg && room;
    assign in_stall      = s1_valid_reg && !room;
    assign accept        = in_valid && !in_stall;
    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sop_byte   <= pdf_pkg::SOP_RESET;
            cfg_reg.max_length <= pdf_pkg::MAXL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == pdf_pkg::CFG_SOP_BYTE)
            begin
                cfg_reg.sop_byte <= cfg_data;
            end
            else if (cfg_index == pdf_pkg::CFG_MAX_LENGTH)
            begin
                cfg_reg.max_length <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    pdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .din       (s1_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    pdf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .din       (res),
        .out_stall (out_stall),
        .room      (room),
        .out_valid (out_valid),
        .dout      (res_out)
    );

    assign has_byte     = res_out.has_byte;
    assign data_byte    = res_out.data_byte;
    assign byte_index   = res_out.byte_index;
    assign frame_type   = res_out.frame_type;
    assign frame_length = res_out.frame_length;
    assign frame_end    = res_out.frame_end;
    assign crc_good     = res_out.crc_good;

endmodule

>>> rtl/pdf_checker.sv
// Port-level checks for the packet deframer and their binding to the top level.
module pdf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       has_byte,
    input logic [7:0] data_byte,
    input logic [7:0] byte_index,
    input logic [7:0] frame_type,
    input logic [7:0] frame_length,
    input logic       frame_end,
    input logic       crc_good
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(byte_index)
            && $stable(frame_end) && $stable(crc_good) && $stable(has_byte)
            && $stable(frame_type) && $stable(frame_length))
        else $error("stalled result changed");

    a_good_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && crc_good |-> frame_end)
        else $error("crc_good set before frame end");

    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> frame_end && frame_length == 8'd0
            && byte_index == 8'd0 && data_byte == 8'd0)
        else $error("malformed empty frame result");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte |->
            (({1'b0, byte_index} + 9'd1 == {1'b0, frame_length}) == frame_end))
        else $error("frame end not on last payload byte");

endmodule

bind packet_deframer_crc16_check pdf_checker u_pdf_checker (.*);
